/* design/sorted_table_find_swap_or_insert_unit_defines.svh */
// Assertion macros shared by the sorted key table design.
`ifndef SORTED_TABLE_FIND_SWAP_OR_INSERT_UNIT_DEFINES_SVH
`define SORTED_TABLE_FIND_SWAP_OR_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STFSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stfsi_pkg.sv */
// Shared types and constants for the sorted key table unit.
package stfsi_pkg;

    localparam int KEY_W               = 32;
    localparam int STATUS_W            = 2;
    localparam int POS_W               = 4;
    localparam int COUNT_W             = 5;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_SWAPPED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FOUND_LAST = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

    // Operation that every cell of the chain performs in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CAPTURE,
        CELL_SHIFT,
        CELL_SWAP,
        CELL_INSERT
    } t_cell_op;

    // Control broadcast from the sequencer to all cells.
    typedef struct packed {
        t_cell_op                 op;
        logic signed [KEY_W-1:0]  key;
    } t_cell_ctl;

endpackage

/* design/stfsi_cell.sv */
// One table cell: holds an entry, its compare flags, and moves data to its neighbors.
module stfsi_cell
    import stfsi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int CELL_IDX    = 0
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_pos,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_cnt,
    input  logic signed [KEY_W-1:0]      i_prev_entry,
    input  logic signed [KEY_W-1:0]      i_next_entry,
    input  logic                         i_next_lt,
    input  logic                         i_next_eq,
    output logic signed [KEY_W-1:0]      o_entry,
    output logic                         o_lt,
    output logic                         o_eq
);

    localparam int                CW  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0]     IDX = CW'(CELL_IDX);

    logic signed [KEY_W-1:0] r_entry;
    logic                    r_lt;
    logic                    r_eq;

    // Entry storage: swap with a neighbor, or take the key or the lower neighbor on insert.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_SWAP: begin
                if (IDX == i_pos) begin
                    r_entry <= i_next_entry;
                end else if (IDX == i_pos + CW'(1)) begin
                    r_entry <= i_prev_entry;
                end
            end
            CELL_INSERT: begin
                if (IDX == i_pos) begin
                    r_entry <= i_ctl.key;
                end else if ((IDX > i_pos) && (IDX <= i_cnt)) begin
                    r_entry <= i_prev_entry;
                end
            end
            default: begin
            end
        endcase
    end

    // Compare flags: captured against the key, then shifted toward the head of the chain.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_CAPTURE: begin
                r_lt <= (r_entry < i_ctl.key);
                r_eq <= (r_entry == i_ctl.key);
            end
            CELL_SHIFT: begin
                r_lt <= i_next_lt;
                r_eq <= i_next_eq;
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

/* design/sorted_table_find_swap_or_insert_unit.sv */
// A new request is taken only while idle (busy low); start is taken again in the strobe cycle.
// The compare flags of the valid cells walk one cell per cycle to the tally at the chain head.
// Reset (i_rst_n low, synchronous) empties the table; entry contents are left as they are.
// The receiver cannot stall: o_valid marks each result for exactly one cycle.
module sorted_table_find_swap_or_insert_unit
    import stfsi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                   o_valid,
    output logic [STATUS_W-1:0]    o_status,
    output logic [POS_W-1:0]       o_position,
    output logic [COUNT_W-1:0]     o_entry_count
);

    `include "sorted_table_find_swap_or_insert_unit_defines.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAPT,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state                   r_state;
    logic signed [KEY_W-1:0]  r_key;
    logic [CW-1:0]            r_n;
    logic [IW-1:0]            r_idx;
    logic [CW-1:0]            r_below;
    logic [IW-1:0]            r_match;
    logic                     r_found;
    logic                     r_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [POS_W-1:0]         r_position;
    logic [COUNT_W-1:0]       r_entry_count;

    logic                     w_accept;
    logic [STATUS_W-1:0]      w_dec_status;
    logic [IW-1:0]            w_dec_pos;
    logic [CW-1:0]            w_dec_n;
    t_cell_op                 w_dec_op;
    t_cell_ctl                w_ctl;
    logic [CW-1:0]            w_pos;

    logic signed [KEY_W-1:0]  w_entry [TABLE_DEPTH];
    logic                     w_lt    [TABLE_DEPTH];
    logic                     w_eq    [TABLE_DEPTH];
    logic signed [KEY_W-1:0]  w_prev  [TABLE_DEPTH];
    logic signed [KEY_W-1:0]  w_next  [TABLE_DEPTH];
    logic                     w_nlt   [TABLE_DEPTH];
    logic                     w_neq   [TABLE_DEPTH];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Outcome of the scan: swap, leave alone, insert, or drop on a full table.
    always_comb begin
        w_dec_status = STATUS_FULL;
        w_dec_pos    = '0;
        w_dec_n      = r_n;
        w_dec_op     = CELL_HOLD;
        if (r_found) begin
            w_dec_pos = r_match;
            if (CW'(r_match) + CW'(1) < r_n) begin
                w_dec_status = STATUS_SWAPPED;
                w_dec_op     = CELL_SWAP;
            end else begin
                w_dec_status = STATUS_FOUND_LAST;
            end
        end else if (r_n < CW'(TABLE_DEPTH)) begin
            w_dec_status = STATUS_INSERTED;
            w_dec_pos    = IW'(r_below);
            w_dec_n      = r_n + CW'(1);
            w_dec_op     = CELL_INSERT;
        end
    end

    // Operation broadcast to the cell chain for the current state.
    always_comb begin
        w_ctl.key = r_key;
        unique case (r_state)
            ST_CAPT:   w_ctl.op = CELL_CAPTURE;
            ST_SCAN:   w_ctl.op = CELL_SHIFT;
            ST_DECIDE: w_ctl.op = w_dec_op;
            default:   w_ctl.op = CELL_HOLD;
        endcase
    end

    assign w_pos = CW'(w_dec_pos);

    // Chain of cells with neighbor links; the ends see the key and cleared flags.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = r_key;
        end else begin : g_body
            assign w_prev[g] = w_entry[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next[g] = r_key;
            assign w_nlt[g]  = 1'b0;
            assign w_neq[g]  = 1'b0;
        end else begin : g_link
            assign w_next[g] = w_entry[g+1];
            assign w_nlt[g]  = w_lt[g+1];
            assign w_neq[g]  = w_eq[g+1];
        end

        stfsi_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_pos        (w_pos),
            .i_cnt        (r_n),
            .i_prev_entry (w_prev[g]),
            .i_next_entry (w_next[g]),
            .i_next_lt    (w_nlt[g]),
            .i_next_eq    (w_neq[g]),
            .o_entry      (w_entry[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Sequencer: capture flags, tally them at the chain head, then apply and report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_key   <= i_key;
                        r_state <= ST_CAPT;
                    end
                end
                ST_CAPT: begin
                    r_idx   <= '0;
                    r_below <= '0;
                    r_found <= 1'b0;
                    r_state <= (r_n == '0) ? ST_DECIDE : ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_lt[0]) begin
                        r_below <= r_below + CW'(1);
                    end
                    if (w_eq[0]) begin
                        r_found <= 1'b1;
                        r_match <= r_idx;
                    end
                    r_idx <= r_idx + IW'(1);
                    if (CW'(r_idx) == r_n - CW'(1)) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_n           <= w_dec_n;
                    r_valid       <= 1'b1;
                    r_status      <= w_dec_status;
                    r_position    <= POS_W'(w_dec_pos);
                    r_entry_count <= COUNT_W'(w_dec_n);
                    r_state       <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

    // Checks on the sequencer and the table fill.
    `STFSI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_n <= CW'(TABLE_DEPTH), "count exceeds table depth")
    `STFSI_ASSERT_NEXT(a_decide_strobe, i_clk, i_rst_n, r_state == ST_DECIDE, o_valid && !busy, "no result after decision")
    `STFSI_ASSERT_NEXT(a_accept_capture, i_clk, i_rst_n, w_accept, r_state == ST_CAPT, "accepted request not captured")
    `STFSI_ASSERT_NOW(a_scan_range, i_clk, i_rst_n, r_state == ST_SCAN, CW'(r_idx) < r_n, "scan ran past the valid entries")

endmodule

/* test/sorted_table_find_swap_or_insert_unit_tb.sv */
// Self-checking testbench for the sorted key table find, swap or insert unit.
module sorted_table_find_swap_or_insert_unit_tb
    import stfsi_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_KEYS    = 800;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = DEPTH + 8;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    // Tracks the table contents and holds the outcomes still to come from the block.
    class key_table_tracker;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [POS_W-1:0]    position;
            logic [COUNT_W-1:0]  entry_count;
        } t_key_outcome;

        logic signed [KEY_W-1:0] held_keys[DEPTH];
        int unsigned             held_count;
        t_key_outcome            pending_outcomes[$];
        int                      mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        // Prints one line per problem and counts it.
        task report(input string msg);
            $display("ERROR at %0t: %0s", $realtime, msg);
            mismatches++;
        endtask

        // Applies an accepted request to the table and queues its outcome.
        function void note_request(input logic signed [KEY_W-1:0] key);
            int unsigned  below;
            int unsigned  match;
            bit           found;
            int unsigned  idx;
            logic signed [KEY_W-1:0] tmp;
            t_key_outcome outcome;
            below = 0;
            match = 0;
            found = 1'b0;
            // Count smaller entries and find the last entry equal to the key.
            for (idx = 0; idx < held_count; idx++) begin
                if (held_keys[idx] < key) begin
                    below++;
                end
                if (held_keys[idx] == key) begin
                    found = 1'b1;
                    match = idx;
                end
            end
            if (found) begin
                outcome.position = match[POS_W-1:0];
                if (match + 1 < held_count) begin
                    tmp                  = held_keys[match];
                    held_keys[match]     = held_keys[match + 1];
                    held_keys[match + 1] = tmp;
                    outcome.status       = STATUS_SWAPPED;
                end else begin
                    outcome.status = STATUS_FOUND_LAST;
                end
            end else if (held_count >= DEPTH) begin
                outcome.status   = STATUS_FULL;
                outcome.position = '0;
            end else begin
                // Shift the larger entries up and drop the key into the gap.
                for (idx = held_count; idx > below; idx--) begin
                    held_keys[idx] = held_keys[idx - 1];
                end
                held_keys[below] = key;
                held_count++;
                outcome.status   = STATUS_INSERTED;
                outcome.position = below[POS_W-1:0];
            end
            outcome.entry_count = held_count[COUNT_W-1:0];
            pending_outcomes.push_back(outcome);
        endfunction

        // Compares one result from the block with the oldest pending outcome.
        task check_result(input logic [STATUS_W-1:0] status,
                          input logic [POS_W-1:0] position,
                          input logic [COUNT_W-1:0] entry_count);
            t_key_outcome want;
            if (pending_outcomes.size() == 0) begin
                report("result strobe with no request outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (status !== want.status) begin
                    report($sformatf("status %0d, expected %0d", status, want.status));
                end
                if (position !== want.position) begin
                    report($sformatf("position %0d, expected %0d", position, want.position));
                end
                if (entry_count !== want.entry_count) begin
                    report($sformatf("entry count %0d, expected %0d",
                                     entry_count, want.entry_count));
                end
            end
        endtask

        // Returns the key stored at an index taken modulo the entry count, or zero when the table is empty.
        function logic signed [KEY_W-1:0] key_at(input int unsigned idx);
            if (held_count == 0) begin
                return '0;
            end
            return held_keys[idx % held_count];
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    busy;
    logic                    o_valid;
    logic [STATUS_W-1:0]     o_status;
    logic [POS_W-1:0]        o_position;
    logic [COUNT_W-1:0]      o_entry_count;

    key_table_tracker tracker = new();
    int               idle_cycles = 0;
    bit               allow_gaps = 1'b1;

    sorted_table_find_swap_or_insert_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Check every result on the cycle it is strobed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            tracker.check_result(o_status, o_position, o_entry_count);
        end
    end

    // Stop the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!allow_gaps || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Presents one request and waits until the block takes it.
    task automatic send_key(input logic signed [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_key <= key;
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.note_request(key);
    endtask

    // Picks a key that mostly hits the table, with neighbors, extremes and noise.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return tracker.key_at($urandom);
        end else if (roll < 70) begin
            return tracker.key_at($urandom) + ($urandom_range(0, 1) ? 1 : -1);
        end else if (roll < 76) begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Reset, directed requests, random requests, then drain and report.
    initial begin
        int idx;
        logic signed [KEY_W-1:0] fill_keys[11];
        fill_keys = '{32'sh5555_5555, 32'shAAAA_AAAA, 100, -100, 7, 32'sh0000_FFFF,
                      32'shFFFF_0000, 2, 3, 32'sh7FFF_FFFE, 32'sh8000_0001};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Insert into an empty table, hit the last entry, and use both extremes.
        send_key(0);
        send_key(0);
        send_key(KEY_MIN);
        send_key(KEY_MAX);
        send_key(KEY_MIN);
        send_key(-1);
        send_key(1);
        // Fill the table to its last slot.
        foreach (fill_keys[i]) begin
            send_key(fill_keys[i]);
        end
        // Full table: absent key is dropped, present keys still swap or stay.
        send_key(32'sh1234_5678);
        send_key(tracker.key_at(DEPTH - 1));
        send_key(tracker.key_at(0));
        send_key(KEY_MAX);

        // Random requests in blocks that alternate between gaps and back-to-back.
        for (idx = 0; idx < RANDOM_KEYS; idx++) begin
            if (idx % 100 == 0) begin
                allow_gaps = (idx / 100) % 2 == 0;
            end
            send_key(pick_key());
        end
        start <= 1'b0;

        // Wait for the outstanding results, then a little longer for strays.
        while (tracker.pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending_outcomes.size() != 0) begin
            tracker.report("results still outstanding at the end of the run");
        end
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
